>>> hdl/arwu_pkg.sv
// Package for the address range watchpoint unit.
// Holds the operation and kind codes, the transaction token that walks the cell chain,
// and the kind-coverage helper. No dependencies.
package arwu_pkg;

    // Operation codes of an input transaction.
    localparam logic [1:0] OP_ADD     = 2'd0;
    localparam logic [1:0] OP_DISABLE = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;
    localparam logic [1:0] OP_WRITE   = 2'd3;

    // Watch kinds.
    localparam logic [1:0] KIND_W  = 2'd0;
    localparam logic [1:0] KIND_RW = 2'd1;
    localparam logic [1:0] KIND_R  = 2'd2;

    // Field widths fixed by the interface.
    localparam int ADDR_W  = 16;
    localparam int KIND_W_BITS = 2;
    localparam int ID_W    = 4;
    localparam int COUNT_W = 5;
    localparam int ID_SPAN = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

    // One transaction as it moves from cell to cell.
    typedef struct packed {
        logic                   valid;
        logic [1:0]             op;
        logic [ADDR_W-1:0]      addr;
        logic [ADDR_W-1:0]      range_end;
        logic [KIND_W_BITS-1:0] watch_kind;
        logic [ID_W-1:0]        entry_id;
        logic                   debugger_access;
        logic                   add_pending;
        logic [ID_W-1:0]        assigned_id;
        logic                   table_full;
        logic                   hit;
        logic [ID_W-1:0]        first_hit_id;
        logic [COUNT_W-1:0]     hit_count;
    } token_t;

    // True when an entry of this kind watches an access of the given direction.
    function automatic logic kind_covers(input logic [1:0] kind, input logic is_write);
        logic covers;
        begin
            if (kind == KIND_RW)
            begin
                covers = 1'b1;
            end
            else if (is_write)
            begin
                covers = (kind == KIND_W);
            end
            else
            begin
                covers = (kind == KIND_R);
            end
            return covers;
        end
    endfunction

endpackage

>>> hdl/arwu_cell.sv
// One watchpoint slot of the chain: range, kind and enable storage plus one comparator.
// Takes the transaction token from its left neighbor and registers it for the next cell when the chain advances.
// Depends on arwu_pkg.
module arwu_cell #(
    parameter int IDX = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  arwu_pkg::token_t tok_in,
    output arwu_pkg::token_t tok_out
);

    // Disable ids only reach the first sixteen slots.
    localparam logic IN_REACH = (IDX < arwu_pkg::ID_SPAN);
    localparam logic [arwu_pkg::ID_W-1:0] MY_ID = arwu_pkg::ID_W'(IDX);

    logic [arwu_pkg::ADDR_W-1:0]      lo_reg;
    logic [arwu_pkg::ADDR_W-1:0]      hi_reg;
    logic [arwu_pkg::KIND_W_BITS-1:0] kind_reg;
    logic                             enabled_reg;
    logic                             enabled_next;
    logic                             used_reg;
    logic                             used_next;
    arwu_pkg::token_t                 tok_reg;
    arwu_pkg::token_t                 tok_next;

    logic claim;
    logic is_access;
    logic match;

    // Slot decisions for the transaction now at this cell.
    always_comb
    begin
        claim     = tok_in.valid && (tok_in.op == arwu_pkg::OP_ADD)
                    && tok_in.add_pending && !used_reg;
        is_access = tok_in.valid && ((tok_in.op == arwu_pkg::OP_READ)
                    || (tok_in.op == arwu_pkg::OP_WRITE)) && !tok_in.debugger_access;
        match     = is_access && enabled_reg
                    && arwu_pkg::kind_covers(kind_reg, tok_in.op == arwu_pkg::OP_WRITE)
                    && (lo_reg <= tok_in.addr) && (tok_in.addr <= hi_reg);

        used_next    = used_reg;
        enabled_next = enabled_reg;
        if (claim)
        begin
            used_next    = 1'b1;
            enabled_next = 1'b1;
        end
        else if (tok_in.valid && (tok_in.op == arwu_pkg::OP_DISABLE) && IN_REACH
                 && (tok_in.entry_id == MY_ID))
        begin
            enabled_next = 1'b0;
        end

        // Update the accumulated match results carried by the token.
        tok_next = tok_in;
        if (claim)
        begin
            tok_next.add_pending = 1'b0;
        end
        if (match)
        begin
            if (!tok_in.hit)
            begin
                tok_next.hit          = 1'b1;
                tok_next.first_hit_id = MY_ID;
            end
            if (tok_in.hit_count < arwu_pkg::COUNT_MAX)
            begin
                tok_next.hit_count = tok_in.hit_count + 5'd1;
            end
        end
    end

    // Control state: slot occupancy, enable and the token register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= 1'b0;
            enabled_reg <= 1'b0;
            tok_reg     <= '0;
        end
        else if (advance)
        begin
            used_reg    <= used_next;
            enabled_reg <= enabled_next;
            tok_reg     <= tok_next;
        end
    end

    // Range and kind storage, written when this slot takes an add.
    always_ff @(posedge clk)
    begin
        if (advance && claim)
        begin
            lo_reg   <= tok_in.addr;
            hi_reg   <= tok_in.range_end;
            kind_reg <= tok_in.watch_kind;
        end
    end

    assign tok_out = tok_reg;

endmodule

>>> hdl/address_range_watchpoint_unit.sv
// Top level of the address range watchpoint unit: fill counter, chain of slot cells
// and output handshake. Depends on arwu_pkg and arwu_cell.
//
// Each transaction enters the head of a chain of ENTRIES slot cells and moves one cell per
// cycle while the chain advances. Every cell compares it with its own range and updates the
// hit flag, lowest hit id and hit count that travel with it. The result is presented at the
// tail from the token register of the last cell. One transaction is accepted every cycle,
// limited only by the consumer: the whole chain holds while the result at its tail waits to
// be taken. Adds claim the first unused slot they pass and disables act on the slot whose
// index they carry, so later accesses always see the effect of earlier adds and disables.
// The slot id and table-full flag of an add are settled at the head from the fill counter.
`default_nettype none
module address_range_watchpoint_unit #(
    parameter int ENTRIES = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  op,
    input  wire logic [15:0] addr,
    input  wire logic [15:0] range_end,
    input  wire logic [1:0]  watch_kind,
    input  wire logic [3:0]  entry_id,
    input  wire logic        debugger_access,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [3:0]       assigned_id,
    output logic             table_full,
    output logic             hit,
    output logic [3:0]       first_hit_id,
    output logic [4:0]       hit_count
);

    localparam int FILL_W = $clog2(ENTRIES + 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(ENTRIES);

    logic [FILL_W-1:0] fill_count_reg;
    logic [FILL_W-1:0] fill_count_next;
    logic              advance;
    logic              accept;
    logic              add_ok;
    arwu_pkg::token_t  head_tok;
    arwu_pkg::token_t  chain [0:ENTRIES];

    // The chain moves whenever the tail result is absent or being taken.
    assign advance  = !chain[ENTRIES].valid || out_ready;
    assign in_ready = advance;
    assign accept   = in_valid && in_ready;

    // Build the head token and the slot assignment of an add.
    always_comb
    begin
        add_ok   = (op == arwu_pkg::OP_ADD) && (fill_count_reg < FILL_MAX);
        head_tok = '0;
        head_tok.valid           = in_valid;
        head_tok.op              = op;
        head_tok.addr            = addr;
        head_tok.range_end       = range_end;
        head_tok.watch_kind      = watch_kind;
        head_tok.entry_id        = entry_id;
        head_tok.debugger_access = debugger_access;
        head_tok.add_pending     = add_ok;
        head_tok.assigned_id     = add_ok ? arwu_pkg::ID_W'(fill_count_reg) : '0;
        head_tok.table_full      = (op == arwu_pkg::OP_ADD) && !add_ok;

        fill_count_next = fill_count_reg;
        if (accept && add_ok)
        begin
            fill_count_next = fill_count_reg + FILL_W'(1);
        end
    end

    // Fill counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
        end
        else
        begin
            fill_count_reg <= fill_count_next;
        end
    end

    assign chain[0] = head_tok;

    // Row of slot cells.
    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        arwu_cell #(
            .IDX (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .tok_in  (chain[g]),
            .tok_out (chain[g+1])
        );
    end

    // Result at the tail of the chain.
    assign out_valid    = chain[ENTRIES].valid;
    assign assigned_id  = chain[ENTRIES].assigned_id;
    assign table_full   = chain[ENTRIES].table_full;
    assign hit          = chain[ENTRIES].hit;
    assign first_hit_id = chain[ENTRIES].first_hit_id;
    assign hit_count    = chain[ENTRIES].hit_count;

    // The hit flag and the hit count agree.
    a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hit == (hit_count != 5'd0)))
        else $error("hit flag disagrees with hit count");

    // A refused add carries no slot id and no match.
    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && table_full) |-> ((assigned_id == 4'd0) && !hit))
        else $error("refused add reports a slot or a hit");

    // The fill counter never passes the table size.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= FILL_MAX)
        else $error("fill counter overflow");

    // An add into a full table leaves the counter unchanged.
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op == arwu_pkg::OP_ADD) && (fill_count_reg == FILL_MAX))
        |=> $stable(fill_count_reg))
        else $error("fill counter moved on a refused add");

endmodule
`default_nettype wire
